// ===== src/vpt_pkg.sv =====
// Shared definitions for the vertex projection transform core.
// Holds register indexes, projection mode codes, reset values and default sizes.
// No dependencies.
package vpt_pkg;

    localparam int COORD_BITS_DEFAULT     = 16;
    localparam int TRIG_FRAC_BITS_DEFAULT = 14;

    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROT_Z      = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROT_X      = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROT_Y      = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT_GAIN = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ZOOM       = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_X   = 4'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_Y   = 4'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE       = 4'd7;

    // Projection modes.
    typedef enum logic [1:0] {
        MODE_ROTATED      = 2'd0,
        MODE_CAVALIER_XY  = 2'd1,
        MODE_CAVALIER_YZ  = 2'd2,
        MODE_CAVALIER_XZ  = 2'd3
    } proj_mode_t;

    // Register reset values.
    localparam logic [31:0]        ROT_RESET    = 32'h4000_0000;
    localparam logic signed [15:0] GAIN_RESET   = 16'sd256;
    localparam logic [19:0]        ZOOM_RESET   = 20'd256;
    localparam logic signed [15:0] OFFSET_RESET = 16'sd0;

    localparam int RESULT_BITS = 32;

endpackage

// ===== src/vertex_projection_transform_core.sv =====
// Vertex projection transform core: rotation / cavalier projection pipeline.
// Depends on vpt_pkg for register indexes, mode codes and reset values.
// Single module; all arithmetic stages live here.

// Channel    | Direction | Handshake              | Payload
// -----------+-----------+------------------------+-------------------------------------
// s_axis     | in        | tvalid / tready        | tdata: grid_x, grid_y, height
// m_axis     | out       | tvalid / tready        | tdata: screen_x, screen_y, scaled_height
// cfg        | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One vertex may enter every clock cycle while the output side is not stalled;
// each result passes through the eight-stage datapath (multiply-add stages
// separated by rounding stages) before it is presented on m_axis.
// Every stage has its own valid bit and advances when it is empty or the stage
// after it advances, so a stalled output fills bubbles before pushing back.
// Reset clears the valid bits and loads the configuration reset values.
// Configuration writes are always accepted (cfg_ready is held high).
module vertex_projection_transform_core #(
    parameter int COORD_BITS     = vpt_pkg::COORD_BITS_DEFAULT,
    parameter int TRIG_FRAC_BITS = vpt_pkg::TRIG_FRAC_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0 up: grid_x, grid_y, height, then zero padding.
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0 up: screen_x, screen_y, scaled_height.
    output logic [3*vpt_pkg::RESULT_BITS-1:0]    m_axis_tdata,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vpt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [vpt_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int C = COORD_BITS;
    localparam int T = TRIG_FRAC_BITS;
    localparam int STAGES = 8;

    // Datapath widths, all derived from the two parameters.
    localparam int HW   = C + 16;                       // height * gain, Q8
    localparam int PW   = C + 17;                       // z rotation results, Q(T)
    localparam int ZW   = C + 8 + T;                    // aligned height, Q(T)
    localparam int R1W  = ((PW > ZW) ? PW : ZW) + 17;   // x rotation sums, Q(2T)
    localparam int Y2W  = R1W - T;                      // x rotation results, Q(T)
    localparam int R2W  = ((PW > Y2W) ? PW : Y2W) + 17; // y rotation sum, Q(2T)
    localparam int X2W  = R2W - T;                      // y rotation result, Q(T)
    localparam int CAVW = C + 33;                       // cavalier sums, Q(T+8)
    localparam int AW   = ((X2W + 8) > CAVW) ? (X2W + 8) : CAVW;
    localparam int LOW  = AW / 2;
    localparam int HIW  = AW - LOW;
    localparam int PLW  = LOW + 20;
    localparam int PHW  = HIW + 21;
    localparam int SD   = T + 16;                       // fraction bits of the screen sum
    localparam int RW0  = AW + 6 - T;
    localparam int RW   = (RW0 > 33) ? RW0 : 33;
    localparam int SW   = RW + SD;
    localparam int SHW  = C + 8;
    localparam int OB   = vpt_pkg::RESULT_BITS;

    localparam logic [R1W-1:0] RND_R1 = {{(R1W-T){1'b0}}, {T{1'b1}}};
    localparam logic [R2W-1:0] RND_R2 = {{(R2W-T){1'b0}}, {T{1'b1}}};
    localparam logic [HW-1:0]  RND_H  = {{(HW-8){1'b0}}, {8{1'b1}}};
    localparam logic [SW-1:0]  RND_S  = {{(SW-SD){1'b0}}, {SD{1'b1}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0]          rot_z_reg, rot_x_reg, rot_y_reg;
    logic signed [15:0]   height_gain_reg;
    logic [19:0]          zoom_reg;
    logic signed [15:0]   offset_x_reg, offset_y_reg;
    vpt_pkg::proj_mode_t  mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_z_reg       <= vpt_pkg::ROT_RESET;
            rot_x_reg       <= vpt_pkg::ROT_RESET;
            rot_y_reg       <= vpt_pkg::ROT_RESET;
            height_gain_reg <= vpt_pkg::GAIN_RESET;
            zoom_reg        <= vpt_pkg::ZOOM_RESET;
            offset_x_reg    <= vpt_pkg::OFFSET_RESET;
            offset_y_reg    <= vpt_pkg::OFFSET_RESET;
            mode_reg        <= vpt_pkg::MODE_ROTATED;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                vpt_pkg::REG_ROT_Z:       rot_z_reg       <= cfg_data;
                vpt_pkg::REG_ROT_X:       rot_x_reg       <= cfg_data;
                vpt_pkg::REG_ROT_Y:       rot_y_reg       <= cfg_data;
                vpt_pkg::REG_HEIGHT_GAIN: height_gain_reg <= cfg_data[15:0];
                vpt_pkg::REG_ZOOM:        zoom_reg        <= cfg_data[19:0];
                vpt_pkg::REG_OFFSET_X:    offset_x_reg    <= cfg_data[15:0];
                vpt_pkg::REG_OFFSET_Y:    offset_y_reg    <= cfg_data[15:0];
                vpt_pkg::REG_MODE:        mode_reg        <= vpt_pkg::proj_mode_t'(cfg_data[1:0]);
                default:                  ;
            endcase
        end
    end

    logic signed [15:0] cz, sz, cx, sx, cy, sy;
    logic signed [20:0] zoom_s;
    logic               rotated;

    assign cz      = rot_z_reg[31:16];
    assign sz      = rot_z_reg[15:0];
    assign cx      = rot_x_reg[31:16];
    assign sx      = rot_x_reg[15:0];
    assign cy      = rot_y_reg[31:16];
    assign sy      = rot_y_reg[15:0];
    assign zoom_s  = {1'b0, zoom_reg};
    assign rotated = (mode_reg == vpt_pkg::MODE_ROTATED);

    // ------------------------------------------------------------------
    // Stage control: a stage loads when it is empty or its successor loads.
    // ------------------------------------------------------------------
    logic [STAGES:1] valid_reg;
    logic [STAGES:1] stage_en;

    always_comb
    begin
        stage_en[STAGES] = !valid_reg[STAGES] || m_axis_tready;
        for (int k = STAGES - 1; k >= 1; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign s_axis_tready = stage_en[1];
    assign m_axis_tvalid = valid_reg[STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[1])
            begin
                valid_reg[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= STAGES; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: height gain and z rotation, cavalier axis choice.
    // ------------------------------------------------------------------
    logic signed [C-1:0]  x_in, y_in, h_in;
    logic signed [C-1:0]  ax_next, ay_next;
    logic signed [HW-1:0] hg_next;
    logic signed [PW-1:0] px_next, py_next;

    assign x_in = s_axis_tdata[C-1:0];
    assign y_in = s_axis_tdata[2*C-1:C];
    assign h_in = s_axis_tdata[3*C-1:2*C];

    assign hg_next = h_in * height_gain_reg;
    assign px_next = x_in * cz - y_in * sz;
    assign py_next = x_in * sz + y_in * cz;

    always_comb
    begin
        case (mode_reg)
            vpt_pkg::MODE_CAVALIER_YZ:
            begin
                ax_next = y_in;
                ay_next = h_in;
            end
            vpt_pkg::MODE_CAVALIER_XZ:
            begin
                ax_next = x_in;
                ay_next = h_in;
            end
            default:
            begin
                ax_next = x_in;
                ay_next = y_in;
            end
        endcase
    end

    logic signed [HW-1:0] hg1_reg;
    logic signed [PW-1:0] px1_reg, py1_reg;
    logic signed [C-1:0]  ax1_reg, ay1_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            hg1_reg <= hg_next;
            px1_reg <= px_next;
            py1_reg <= py_next;
            ax1_reg <= ax_next;
            ay1_reg <= ay_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: x rotation sums, cavalier sums, height rounding.
    // The new z uses the y from before the x rotation.
    // ------------------------------------------------------------------
    logic signed [R1W-1:0]  ysum_next, zsum_next;
    logic signed [CAVW-1:0] cavx_next, cavy_next;
    logic [HW-1:0]          hg_rnd;

    assign ysum_next = py1_reg * cx - ((hg1_reg * sx) <<< (T - 8));
    assign zsum_next = py1_reg * sx + ((hg1_reg * cx) <<< (T - 8));
    assign cavx_next = (ax1_reg <<< (T + 8)) + hg1_reg * cz;
    assign cavy_next = (ay1_reg <<< (T + 8)) + hg1_reg * sz;
    assign hg_rnd    = hg1_reg[HW-1] ? (hg1_reg + RND_H) : hg1_reg;

    logic signed [R1W-1:0]  ysum2_reg, zsum2_reg;
    logic signed [PW-1:0]   px2_reg;
    logic signed [CAVW-1:0] cavx2_reg, cavy2_reg;
    logic signed [SHW-1:0]  sh2_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            ysum2_reg <= ysum_next;
            zsum2_reg <= zsum_next;
            px2_reg   <= px1_reg;
            cavx2_reg <= cavx_next;
            cavy2_reg <= cavy_next;
            sh2_reg   <= hg_rnd[HW-1:8];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: truncate the x rotation results toward zero.
    // ------------------------------------------------------------------
    logic [R1W-1:0] ysum_rnd, zsum_rnd;

    assign ysum_rnd = ysum2_reg[R1W-1] ? (ysum2_reg + RND_R1) : ysum2_reg;
    assign zsum_rnd = zsum2_reg[R1W-1] ? (zsum2_reg + RND_R1) : zsum2_reg;

    logic signed [Y2W-1:0]  y3_reg, z3_reg;
    logic signed [PW-1:0]   px3_reg;
    logic signed [CAVW-1:0] cavx3_reg, cavy3_reg;
    logic signed [SHW-1:0]  sh3_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            y3_reg    <= ysum_rnd[R1W-1:T];
            z3_reg    <= zsum_rnd[R1W-1:T];
            px3_reg   <= px2_reg;
            cavx3_reg <= cavx2_reg;
            cavy3_reg <= cavy2_reg;
            sh3_reg   <= sh2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: y rotation of x.
    // ------------------------------------------------------------------
    logic signed [R2W-1:0] xsum_next;

    assign xsum_next = px3_reg * cy + z3_reg * sy;

    logic signed [R2W-1:0]  xsum4_reg;
    logic signed [Y2W-1:0]  y4_reg;
    logic signed [CAVW-1:0] cavx4_reg, cavy4_reg;
    logic signed [SHW-1:0]  sh4_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            xsum4_reg <= xsum_next;
            y4_reg    <= y3_reg;
            cavx4_reg <= cavx3_reg;
            cavy4_reg <= cavy3_reg;
            sh4_reg   <= sh3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: truncate x, then bring both modes to Q(T+8) and pick one.
    // ------------------------------------------------------------------
    logic [R2W-1:0]        xsum_rnd;
    logic signed [X2W-1:0] x_rot;
    logic signed [AW-1:0]  ax5_next, ay5_next;

    assign xsum_rnd = xsum4_reg[R2W-1] ? (xsum4_reg + RND_R2) : xsum4_reg;
    assign x_rot    = xsum_rnd[R2W-1:T];
    assign ax5_next = rotated ? (AW'(x_rot) <<< 8) : AW'(cavx4_reg);
    assign ay5_next = rotated ? (AW'(y4_reg) <<< 8) : AW'(cavy4_reg);

    logic signed [AW-1:0]  ax5_reg, ay5_reg;
    logic signed [SHW-1:0] sh5_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            ax5_reg <= ax5_next;
            ay5_reg <= ay5_next;
            sh5_reg <= sh4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: zoom product, split into low and high partial products.
    // ------------------------------------------------------------------
    logic [LOW-1:0]        ax_lo, ay_lo;
    logic signed [HIW-1:0] ax_hi, ay_hi;
    logic [PLW-1:0]        plx_next, ply_next;
    logic signed [PHW-1:0] phx_next, phy_next;

    assign ax_lo    = ax5_reg[LOW-1:0];
    assign ay_lo    = ay5_reg[LOW-1:0];
    assign ax_hi    = ax5_reg[AW-1:LOW];
    assign ay_hi    = ay5_reg[AW-1:LOW];
    assign plx_next = ax_lo * zoom_reg;
    assign ply_next = ay_lo * zoom_reg;
    assign phx_next = ax_hi * zoom_s;
    assign phy_next = ay_hi * zoom_s;

    logic [PLW-1:0]        plx6_reg, ply6_reg;
    logic signed [PHW-1:0] phx6_reg, phy6_reg;
    logic signed [SHW-1:0] sh6_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            plx6_reg <= plx_next;
            ply6_reg <= ply_next;
            phx6_reg <= phx_next;
            phy6_reg <= phy_next;
            sh6_reg  <= sh5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: join partial products and add the offset at full precision.
    // ------------------------------------------------------------------
    logic [SW-1:0] sum_x_next, sum_y_next;

    assign sum_x_next = (SW'(phx6_reg) <<< LOW) + SW'(plx6_reg) + (SW'(offset_x_reg) <<< SD);
    assign sum_y_next = (SW'(phy6_reg) <<< LOW) + SW'(ply6_reg) + (SW'(offset_y_reg) <<< SD);

    logic [SW-1:0]         sum_x7_reg, sum_y7_reg;
    logic signed [SHW-1:0] sh7_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[7])
        begin
            sum_x7_reg <= sum_x_next;
            sum_y7_reg <= sum_y_next;
            sh7_reg    <= sh6_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: truncate toward zero, saturate, and hold as the output.
    // ------------------------------------------------------------------
    logic [SW-1:0]         sum_x_rnd, sum_y_rnd;
    logic signed [RW-1:0]  rx, ry;
    logic signed [OB-1:0]  screen_x_next, screen_y_next;

    assign sum_x_rnd = sum_x7_reg[SW-1] ? (sum_x7_reg + RND_S) : sum_x7_reg;
    assign sum_y_rnd = sum_y7_reg[SW-1] ? (sum_y7_reg + RND_S) : sum_y7_reg;
    assign rx        = sum_x_rnd[SW-1:SD];
    assign ry        = sum_y_rnd[SW-1:SD];

    always_comb
    begin
        if (rx[RW-1:OB-1] == {(RW-OB+1){rx[OB-1]}})
        begin
            screen_x_next = rx[OB-1:0];
        end
        else
        begin
            screen_x_next = {rx[RW-1], {(OB-1){~rx[RW-1]}}};
        end
        if (ry[RW-1:OB-1] == {(RW-OB+1){ry[OB-1]}})
        begin
            screen_y_next = ry[OB-1:0];
        end
        else
        begin
            screen_y_next = {ry[RW-1], {(OB-1){~ry[RW-1]}}};
        end
    end

    logic signed [OB-1:0] screen_x8_reg, screen_y8_reg, sh8_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[8])
        begin
            screen_x8_reg <= screen_x_next;
            screen_y8_reg <= screen_y_next;
            sh8_reg       <= OB'(sh7_reg);
        end
    end

    assign m_axis_tdata = {sh8_reg, screen_y8_reg, screen_x8_reg};

`ifndef NO_ASSERTIONS
    // A full pipeline behind a stalled output must refuse new input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while pipeline full and output stalled");

    // An accepted input transaction always lands in the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> valid_reg[1])
    else $error("accepted vertex lost at stage 1");

    // A held item in the offset stage keeps its sums.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[7] && !stage_en[7]) |=> ($stable(sum_x7_reg) && $stable(sum_y7_reg)))
    else $error("stalled screen sums changed");

    // A result taken with nothing behind it leaves the output empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !valid_reg[7]) |=> !m_axis_tvalid)
    else $error("result repeated at output");
`endif

endmodule

// ===== bench/vertex_projection_checker.sv =====
// Result checker for the vertex projection transform core.
// Tracks the register file from configuration transactions, predicts each vertex's
// screen result and compares it against the output stream. Depends on vpt_pkg.
`timescale 1ns / 1ps

module vertex_projection_checker #(
    parameter int COORD_BITS     = vpt_pkg::COORD_BITS_DEFAULT,
    parameter int TRIG_FRAC_BITS = vpt_pkg::TRIG_FRAC_BITS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   s_axis_tvalid,
    input  logic                                   s_axis_tready,
    // Fields from bit 0 up: grid_x, grid_y, height, then zero padding.
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,

    input  logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // Fields from bit 0 up: screen_x, screen_y, scaled_height.
    input  logic [3*vpt_pkg::RESULT_BITS-1:0]      m_axis_tdata,

    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [vpt_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [vpt_pkg::CFG_DATA_BITS-1:0]      cfg_data,

    output int                                     mismatches,
    output int                                     outstanding,
    output int                                     checked
);

    typedef struct packed {
        logic signed [31:0] scaled_height;
        logic signed [31:0] screen_y;
        logic signed [31:0] screen_x;
    } screen_point_t;

    localparam logic signed [127:0] SAT_HI = 128'sd2147483647;
    localparam logic signed [127:0] SAT_LO = -128'sd2147483648;

    // Local copy of the register file.
    logic [31:0]          rot_z;
    logic [31:0]          rot_x;
    logic [31:0]          rot_y;
    logic signed [15:0]   gain;
    logic [19:0]          zoom_q;
    logic signed [15:0]   off_x;
    logic signed [15:0]   off_y;
    vpt_pkg::proj_mode_t  mode;

    screen_point_t expected_points[$];
    int            inflight;
    int            errs;
    int            nchecked;

    function automatic longint trunc_shift(longint v, int n);
        return (v < 0) ? -((-v) >>> n) : (v >>> n);
    endfunction

    // Scale a fixed-point value with fb fraction bits by zoom/256, add the
    // offset, truncate toward zero once and saturate to 32 bits.
    function automatic logic signed [31:0] screen_coord(longint a, int fb,
                                                        logic signed [15:0] off);
        logic signed [127:0] acc;
        logic signed [127:0] wide_zoom;
        logic signed [127:0] wide_off;
        logic signed [127:0] q;
        int                  d;
        d         = fb + 8;
        acc       = a;
        wide_zoom = {108'd0, zoom_q};
        wide_off  = off;
        acc       = acc * wide_zoom + (wide_off <<< d);
        q         = (acc < 0) ? -((-acc) >>> d) : (acc >>> d);
        if (q > SAT_HI)
            q = SAT_HI;
        if (q < SAT_LO)
            q = SAT_LO;
        return q[31:0];
    endfunction

    function automatic screen_point_t project_vertex(logic signed [COORD_BITS-1:0] x,
                                                     logic signed [COORD_BITS-1:0] y,
                                                     logic signed [COORD_BITS-1:0] h);
        screen_point_t p;
        longint gx, gy, gh, hg, cz, sz, cx, sx, cy, sy;
        longint px, py, pz, py2, pz2, px2, unit, ax, ay;
        gx = x;
        gy = y;
        gh = h;
        hg = gh * gain;
        cz = $signed(rot_z[31:16]);
        sz = $signed(rot_z[15:0]);
        cx = $signed(rot_x[31:16]);
        sx = $signed(rot_x[15:0]);
        cy = $signed(rot_y[31:16]);
        sy = $signed(rot_y[15:0]);
        if (mode == vpt_pkg::MODE_ROTATED)
        begin
            px  = gx * cz - gy * sz;
            py  = gx * sz + gy * cz;
            pz  = hg <<< (TRIG_FRAC_BITS - 8);
            // The new z is formed from the y that entered the x rotation.
            py2 = trunc_shift(py * cx - pz * sx, TRIG_FRAC_BITS);
            pz2 = trunc_shift(py * sx + pz * cx, TRIG_FRAC_BITS);
            px2 = trunc_shift(px * cy + pz2 * sy, TRIG_FRAC_BITS);
            p.screen_x = screen_coord(px2, TRIG_FRAC_BITS, off_x);
            p.screen_y = screen_coord(py2, TRIG_FRAC_BITS, off_y);
        end
        else
        begin
            unit = longint'(1) <<< (TRIG_FRAC_BITS + 8);
            case (mode)
                vpt_pkg::MODE_CAVALIER_XY:
                begin
                    ax = gx;
                    ay = gy;
                end
                vpt_pkg::MODE_CAVALIER_YZ:
                begin
                    ax = gy;
                    ay = gh;
                end
                default:
                begin
                    ax = gx;
                    ay = gh;
                end
            endcase
            p.screen_x = screen_coord(ax * unit + hg * cz, TRIG_FRAC_BITS + 8, off_x);
            p.screen_y = screen_coord(ay * unit + hg * sz, TRIG_FRAC_BITS + 8, off_y);
        end
        p.scaled_height = 32'(trunc_shift(hg, 8));
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        screen_point_t got;
        screen_point_t want;
        if (!rst_n)
        begin
            rot_z    = vpt_pkg::ROT_RESET;
            rot_x    = vpt_pkg::ROT_RESET;
            rot_y    = vpt_pkg::ROT_RESET;
            gain     = vpt_pkg::GAIN_RESET;
            zoom_q   = vpt_pkg::ZOOM_RESET;
            off_x    = vpt_pkg::OFFSET_RESET;
            off_y    = vpt_pkg::OFFSET_RESET;
            mode     = vpt_pkg::MODE_ROTATED;
            expected_points.delete();
            inflight = 0;
            errs     = 0;
            nchecked = 0;
            mismatches  <= 0;
            outstanding <= 0;
            checked     <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                // Bits above a register's width are dropped.
                case (cfg_index)
                    vpt_pkg::REG_ROT_Z:       rot_z  = cfg_data;
                    vpt_pkg::REG_ROT_X:       rot_x  = cfg_data;
                    vpt_pkg::REG_ROT_Y:       rot_y  = cfg_data;
                    vpt_pkg::REG_HEIGHT_GAIN: gain   = cfg_data[15:0];
                    vpt_pkg::REG_ZOOM:        zoom_q = cfg_data[19:0];
                    vpt_pkg::REG_OFFSET_X:    off_x  = cfg_data[15:0];
                    vpt_pkg::REG_OFFSET_Y:    off_y  = cfg_data[15:0];
                    vpt_pkg::REG_MODE:        mode   = vpt_pkg::proj_mode_t'(cfg_data[1:0]);
                    default:                  ;
                endcase
            end

            // Outputs are checked before this edge's input is queued, so a
            // result can never be matched against its own vertex too early.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_points.size() == 0)
                begin
                    $error("result with no vertex pending: %h", m_axis_tdata);
                    errs++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    inflight--;
                    nchecked++;
                    if (got.screen_x !== want.screen_x)
                    begin
                        $error("screen_x: expected %0d, got %0d",
                               want.screen_x, got.screen_x);
                        errs++;
                    end
                    if (got.screen_y !== want.screen_y)
                    begin
                        $error("screen_y: expected %0d, got %0d",
                               want.screen_y, got.screen_y);
                        errs++;
                    end
                    if (got.scaled_height !== want.scaled_height)
                    begin
                        $error("scaled_height: expected %0d, got %0d",
                               want.scaled_height, got.scaled_height);
                        errs++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_points.push_back(project_vertex(
                    s_axis_tdata[COORD_BITS-1:0],
                    s_axis_tdata[2*COORD_BITS-1:COORD_BITS],
                    s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]));
                inflight++;
            end

            mismatches  <= errs;
            outstanding <= inflight;
            checked     <= nchecked;
        end
    end

endmodule

// ===== bench/tb_vertex_projection_transform_core.sv =====
// Testbench top for the vertex projection transform core.
// Generates vertex, configuration and back-pressure stimulus and reports the verdict;
// all prediction and comparison lives in vertex_projection_checker. Depends on vpt_pkg.
`timescale 1ns / 1ps

module tb_vertex_projection_transform_core;

    localparam int CB   = vpt_pkg::COORD_BITS_DEFAULT;
    localparam int TF   = vpt_pkg::TRIG_FRAC_BITS_DEFAULT;
    localparam int DW   = ((3*CB+7)/8)*8;
    localparam int RW   = 3*vpt_pkg::RESULT_BITS;
    localparam int IDXW = vpt_pkg::CFG_INDEX_BITS;
    localparam int CDW  = vpt_pkg::CFG_DATA_BITS;

    // The pipeline is eight stages deep; the settle wait lets it run empty.
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 120;

    localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

    // One full set of register values, written as a group while the core is idle.
    typedef struct {
        logic [31:0]          rot_z;
        logic [31:0]          rot_x;
        logic [31:0]          rot_y;
        logic signed [15:0]   gain;
        logic [19:0]          zoom;
        logic signed [15:0]   off_x;
        logic signed [15:0]   off_y;
        vpt_pkg::proj_mode_t  mode;
    } reg_set_t;

    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [DW-1:0]              s_axis_tdata  = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [RW-1:0]              m_axis_tdata;
    logic                       cfg_valid     = 1'b0;
    logic                       cfg_ready;
    logic [IDXW-1:0]            cfg_index     = '0;
    logic [CDW-1:0]             cfg_data      = '0;

    int mismatches;
    int outstanding;
    int checked;

    // When set, both the vertex source and the result sink run without gaps.
    logic calm = 1'b0;
    int   stall_left = 0;
    int   sent = 0;
    int   settings_applied = 0;

    // Q1.14 cosines for 0, 30, 45, 60 and 90 degrees; the sines are the same
    // table read backward.
    logic signed [15:0] cos_tab [5] = '{16'sd16384, 16'sd14189, 16'sd11585, 16'sd8192, 16'sd0};
    logic [15:0]        trig_edge [5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h4000, 16'hC000};

    // Directed vertices: the origin, all-max, all-min, mixed extremes and a
    // small mixed-sign point.
    logic signed [CB-1:0] dir_x [5] = '{'0, C_MAX, C_MIN, C_MAX, -CB'(3)};
    logic signed [CB-1:0] dir_y [5] = '{'0, C_MAX, C_MIN, C_MIN, CB'(5)};
    logic signed [CB-1:0] dir_h [5] = '{'0, C_MAX, C_MIN, CB'(1), -CB'(7)};

    vertex_projection_transform_core #(
        .COORD_BITS     (CB),
        .TRIG_FRAC_BITS (TF)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    vertex_projection_checker #(
        .COORD_BITS     (CB),
        .TRIG_FRAC_BITS (TF)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .checked       (checked)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Idle length for the vertex source: mostly none or short, now and
    // then a long pause so gaps land on every pipeline stage.
    function automatic int idle_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Result sink back-pressure. Each clock edge either continues a stall,
    // starts a new one, or accepts. Only one assignment to tready per edge.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 99) < 20)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                        : $urandom_range(5, 29);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // One input transaction. The valid flag is left high afterward so that
    // back-to-back vertices keep it asserted without a drop in between.
    task automatic send_vertex(input logic [CB-1:0] gx, input logic [CB-1:0] gy,
                               input logic [CB-1:0] gh);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DW'({gh, gy, gx});
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    // One configuration transaction; the caller drops cfg_valid after the last.
    task automatic put_reg(input logic [IDXW-1:0] idx, input logic [CDW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Writes every register. Narrow registers get random junk above their
    // width, which the core must drop, and about half the time a write to an
    // index past the register map is slipped in; it must change nothing.
    task automatic apply_setting(input reg_set_t s);
        put_reg(vpt_pkg::REG_ROT_Z, s.rot_z);
        put_reg(vpt_pkg::REG_ROT_X, s.rot_x);
        if ($urandom_range(0, 1) == 1)
            put_reg(vpt_pkg::REG_MODE + IDXW'($urandom_range(1, 7)), $urandom);
        put_reg(vpt_pkg::REG_ROT_Y, s.rot_y);
        put_reg(vpt_pkg::REG_HEIGHT_GAIN, {16'($urandom), s.gain});
        put_reg(vpt_pkg::REG_ZOOM, {12'($urandom), s.zoom});
        put_reg(vpt_pkg::REG_OFFSET_X, {16'($urandom), s.off_x});
        put_reg(vpt_pkg::REG_OFFSET_Y, {16'($urandom), s.off_y});
        put_reg(vpt_pkg::REG_MODE, {30'($urandom), s.mode});
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings_applied++;
    endtask

    // Stops the source, waits for every predicted result to come back, then
    // lets the pipeline run empty before anything else happens.
    task automatic drain();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_trig();
        logic signed [15:0] c;
        logic signed [15:0] s;
        int                 k;
        int                 r;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            // A real angle with random quadrant.
            k = $urandom_range(0, 4);
            c = cos_tab[k];
            s = cos_tab[4-k];
            if ($urandom_range(0, 1) == 1)
                c = -c;
            if ($urandom_range(0, 1) == 1)
                s = -s;
            return {c, s};
        end
        if (r < 75)
            return $urandom;
        // Unnormalized pairs built from the extremes of the Q1.14 range.
        return {trig_edge[$urandom_range(0, 4)], trig_edge[$urandom_range(0, 4)]};
    endfunction

    function automatic logic signed [15:0] rand_offset();
        if ($urandom_range(0, 9) < 7)
            return 16'($signed($urandom_range(0, 4000)) - 2000);
        return 16'($urandom);
    endfunction

    function automatic reg_set_t rand_setting(input vpt_pkg::proj_mode_t m);
        reg_set_t s;
        int       r;
        s.rot_z = rand_trig();
        s.rot_x = rand_trig();
        s.rot_y = rand_trig();
        r = $urandom_range(0, 99);
        if (r < 50)
            s.gain = 16'($signed($urandom_range(0, 1024)) - 512);
        else if (r < 85)
            s.gain = 16'($urandom);
        else
            s.gain = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
        r = $urandom_range(0, 99);
        if (r < 55)
            s.zoom = 20'($urandom_range(1, 2048));
        else if (r < 70)
            s.zoom = '0;
        else if (r < 90)
            s.zoom = 20'($urandom);
        else
            s.zoom = '1;
        s.off_x = rand_offset();
        s.off_y = rand_offset();
        s.mode  = m;
        return s;
    endfunction

    // Mostly small coordinates so results stay in range and the arithmetic is
    // easy to follow; a good share are full-width values that toggle every
    // bit and drive the screen values into saturation.
    function automatic logic [CB-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return CB'($signed($urandom_range(0, 2000)) - 1000);
        if (r < 90)
            return CB'($urandom);
        case ($urandom_range(0, 3))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    initial
    begin
        reg_set_t s;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The first pass runs on the reset values: identity
        // angles, unit gain and zoom, mode zero.
        for (int i = 0; i < 5; i++)
            send_vertex(dir_x[i], dir_y[i], dir_h[i]);
        drain();

        // Rotated mode with unnormalized x angle, most negative gain, full-scale
        // zoom and extreme offsets, which pushes the screen values to saturation.
        s = '{32'h2D41_2D41, 32'h7FFF_8000, 32'h376D_2000, 16'sh8000, 20'hFFFFF,
              16'sh7FFF, 16'sh8000, vpt_pkg::MODE_ROTATED};
        apply_setting(s);
        for (int i = 0; i < 5; i++)
            send_vertex(dir_x[i], dir_y[i], dir_h[i]);
        drain();

        // Cavalier xy with zoom zero: every position must equal the offsets.
        s = '{32'h2D41_2D41, vpt_pkg::ROT_RESET, vpt_pkg::ROT_RESET, vpt_pkg::GAIN_RESET,
              20'd0, 16'sd123, -16'sd456, vpt_pkg::MODE_CAVALIER_XY};
        apply_setting(s);
        for (int i = 0; i < 5; i++)
            send_vertex(dir_x[i], dir_y[i], dir_h[i]);
        drain();

        // Cavalier yz at 45 degrees with unit gain and zoom.
        s = '{32'h2D41_2D41, 32'h376D_2000, 32'h2000_376D, vpt_pkg::GAIN_RESET,
              vpt_pkg::ZOOM_RESET, vpt_pkg::OFFSET_RESET, vpt_pkg::OFFSET_RESET,
              vpt_pkg::MODE_CAVALIER_YZ};
        apply_setting(s);
        for (int i = 0; i < 5; i++)
            send_vertex(dir_x[i], dir_y[i], dir_h[i]);
        drain();

        // Cavalier xz with an unnormalized z angle, largest gain and the
        // smallest non-zero zoom.
        s = '{32'h8000_7FFF, 32'h0000_4000, 32'hC000_0000, 16'sh7FFF, 20'd1,
              16'sh8000, 16'sh7FFF, vpt_pkg::MODE_CAVALIER_XZ};
        apply_setting(s);
        for (int i = 0; i < 5; i++)
            send_vertex(dir_x[i], dir_y[i], dir_h[i]);
        drain();

        // Random part: each phase picks a fresh register set, cycling through
        // the four modes, and about a quarter of the phases run with no idling at all.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            apply_setting(rand_setting(vpt_pkg::proj_mode_t'(p % 4)));
            calm <= ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_vertex(rand_coord(), rand_coord(), rand_coord());
            drain();
            calm <= 1'b0;
        end

        if (outstanding != 0)
            $error("%0d predicted results never came out", outstanding);

        $display("Checked %0d results from %0d vertices over %0d register settings.",
                 checked, sent, settings_applied + 1);
        $display("Covered all projection modes, zero and full-scale zoom, saturation,"
                 , " unnormalized angles and writes outside the register map.");
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
